// ===== sv/kmcf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmcf_pkg: shared types and codes of the keyed message FIFO
// Operation and status codes, controller states, the command bundle and the
// stored descriptor layout.
// ----------------------------------------------------------------------------
package kmcf_pkg;

    // operation codes
    localparam logic [1:0] OP_OPEN  = 2'd0;
    localparam logic [1:0] OP_CLOSE = 2'd1;
    localparam logic [1:0] OP_PUSH  = 2'd2;
    localparam logic [1:0] OP_POP   = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NONE_OPEN  = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd2;
    localparam logic [2:0] ST_FULL_EMPTY = 3'd3;
    localparam logic [2:0] ST_TABLE_FULL = 3'd4;
    localparam logic [2:0] ST_DUPLICATE  = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_EXEC,
        S_HEAD,
        S_FINISH
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic lookup;
        logic exec;
        logic head;
        logic finish;
    } cmd_t;

    // one stored message descriptor
    typedef struct packed {
        logic [31:0] header;
        logic [15:0] source;
        logic [15:0] dest;
        logic [15:0] mtype;
        logic [23:0] length;
        logic [31:0] handle;
    } desc_t;

    localparam int DESC_W = $bits(desc_t);

endpackage

// ===== sv/kmcf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmcf_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module kmcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/kmcf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmcf_ctrl: operation sequencer
// Steps each accepted word through lookup, execute, head read and finish.
// ----------------------------------------------------------------------------
module kmcf_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    output kmcf_pkg::cmd_t cmd
);

    kmcf_pkg::state_t state_reg;
    kmcf_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kmcf_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            kmcf_pkg::S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = kmcf_pkg::S_LOOKUP;
                end
            end
            kmcf_pkg::S_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = kmcf_pkg::S_EXEC;
            end
            kmcf_pkg::S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = kmcf_pkg::S_HEAD;
            end
            kmcf_pkg::S_HEAD:
            begin
                cmd.head   = 1'b1;
                state_next = kmcf_pkg::S_FINISH;
            end
            kmcf_pkg::S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = kmcf_pkg::S_IDLE;
            end
            default:
            begin
                state_next = kmcf_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/kmcf_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmcf_dp: channel table and descriptor datapath
// Key match over the slot table, per-slot ring pointers, descriptor RAM and
// result registers.
// ----------------------------------------------------------------------------
module kmcf_dp #(
    parameter int CHANNELS = 8,
    parameter int DEPTH    = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  kmcf_pkg::cmd_t cmd,
    input  logic [1:0]     op,
    input  logic [30:0]    channel_key,
    input  logic [31:0]    header_word,
    input  logic [15:0]    source_client,
    input  logic [15:0]    dest_client,
    input  logic [15:0]    message_type,
    input  logic [23:0]    message_length,
    input  logic [31:0]    payload_handle,
    output logic           done,
    output logic [2:0]     status,
    output logic [31:0]    out_header,
    output logic [15:0]    out_source,
    output logic [15:0]    out_dest,
    output logic [15:0]    out_type,
    output logic [23:0]    out_length,
    output logic [31:0]    out_handle,
    output logic           now_full,
    output logic           now_empty,
    output logic [23:0]    head_length
);

    localparam int SW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PW = $clog2(DEPTH);
    localparam int CW = PW + 1;
    localparam int AW = $clog2(CHANNELS * DEPTH);

    // latched command word
    logic [1:0]      op_reg;
    logic [30:0]     key_reg;
    kmcf_pkg::desc_t in_desc_reg;

    // slot table
    logic          used_reg [CHANNELS];
    logic [30:0]   skey_reg [CHANNELS];
    logic [PW-1:0] rp_reg   [CHANNELS];
    logic [PW-1:0] wp_reg   [CHANNELS];

    // lookup results
    logic          hit, any_open, free_ok;
    logic [SW-1:0] hit_idx, free_idx;
    logic          hit_reg, any_reg, free_ok_reg;
    logic [SW-1:0] hit_idx_reg, free_idx_reg;

    // execute results
    logic [2:0]    status_next, status_reg;
    logic          slot_ok_next, slot_ok_reg;
    logic [SW-1:0] slot_next, slot_reg;
    logic          push_ok, pop_ok, pop_ok_reg;
    logic          open_ok, close_ok;
    logic [CW-1:0] hit_cnt, fin_cnt;

    // RAM ports
    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr, ram_raddr, exec_raddr, head_raddr;
    logic [kmcf_pkg::DESC_W-1:0]   ram_rdata;
    kmcf_pkg::desc_t               rd_desc, desc_reg;

    function automatic logic [CW-1:0] ring_count(input logic [PW-1:0] r,
                                                  input logic [PW-1:0] w);
        logic [CW-1:0] res;
        if (w >= r)
        begin
            res = CW'(w) - CW'(r);
        end
        else
        begin
            res = CW'(w) + CW'(DEPTH) - CW'(r);
        end
        return res;
    endfunction

    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [AW-1:0] ent_addr(input logic [SW-1:0] s,
                                                input logic [PW-1:0] p);
        return AW'(AW'(s) * AW'(DEPTH)) + AW'(p);
    endfunction

    // key match and free slot search
    always_comb
    begin
        hit      = 1'b0;
        hit_idx  = '0;
        any_open = 1'b0;
        free_ok  = 1'b0;
        free_idx = '0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (used_reg[i])
            begin
                any_open = 1'b1;
            end
            if (used_reg[i] && skey_reg[i] == key_reg && !hit)
            begin
                hit     = 1'b1;
                hit_idx = SW'(i);
            end
            if (!used_reg[i] && !free_ok)
            begin
                free_ok  = 1'b1;
                free_idx = SW'(i);
            end
        end
    end

    // operation decision
    always_comb
    begin
        hit_cnt      = ring_count(rp_reg[hit_idx_reg], wp_reg[hit_idx_reg]);
        status_next  = kmcf_pkg::ST_OK;
        slot_ok_next = hit_reg;
        slot_next    = hit_idx_reg;
        open_ok      = 1'b0;
        close_ok     = 1'b0;
        push_ok      = 1'b0;
        pop_ok       = 1'b0;
        if (op_reg == kmcf_pkg::OP_OPEN)
        begin
            if (hit_reg)
            begin
                status_next = kmcf_pkg::ST_DUPLICATE;
            end
            else if (!free_ok_reg)
            begin
                status_next = kmcf_pkg::ST_TABLE_FULL;
            end
            else
            begin
                open_ok      = 1'b1;
                slot_ok_next = 1'b1;
                slot_next    = free_idx_reg;
            end
        end
        else if (!any_reg)
        begin
            status_next = kmcf_pkg::ST_NONE_OPEN;
        end
        else if (!hit_reg)
        begin
            status_next = kmcf_pkg::ST_NOT_FOUND;
        end
        else if (op_reg == kmcf_pkg::OP_CLOSE)
        begin
            close_ok     = 1'b1;
            slot_ok_next = 1'b0;
        end
        else if (op_reg == kmcf_pkg::OP_PUSH)
        begin
            if (hit_cnt >= CW'(DEPTH - 1))
            begin
                status_next = kmcf_pkg::ST_FULL_EMPTY;
            end
            else
            begin
                push_ok = 1'b1;
            end
        end
        else
        begin
            if (hit_cnt == '0)
            begin
                status_next = kmcf_pkg::ST_FULL_EMPTY;
            end
            else
            begin
                pop_ok = 1'b1;
            end
        end
    end

    // input latch and lookup / execute / head registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg             <= op;
            key_reg            <= channel_key;
            in_desc_reg.header <= header_word;
            in_desc_reg.source <= source_client;
            in_desc_reg.dest   <= dest_client;
            in_desc_reg.mtype  <= message_type;
            in_desc_reg.length <= message_length;
            in_desc_reg.handle <= payload_handle;
        end
        if (cmd.lookup)
        begin
            hit_reg      <= hit;
            hit_idx_reg  <= hit_idx;
            any_reg      <= any_open;
            free_ok_reg  <= free_ok;
            free_idx_reg <= free_idx;
        end
        if (cmd.exec)
        begin
            status_reg  <= status_next;
            slot_ok_reg <= slot_ok_next;
            slot_reg    <= slot_next;
            pop_ok_reg  <= pop_ok;
        end
        if (cmd.head)
        begin
            desc_reg <= pop_ok_reg ? rd_desc : '0;
        end
    end

    // slot table update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                used_reg[i] <= 1'b0;
                skey_reg[i] <= '0;
                rp_reg[i]   <= '0;
                wp_reg[i]   <= '0;
            end
        end
        else if (cmd.exec)
        begin
            if (open_ok)
            begin
                used_reg[free_idx_reg] <= 1'b1;
                skey_reg[free_idx_reg] <= key_reg;
                rp_reg[free_idx_reg]   <= '0;
                wp_reg[free_idx_reg]   <= '0;
            end
            if (close_ok)
            begin
                used_reg[hit_idx_reg] <= 1'b0;
                skey_reg[hit_idx_reg] <= '0;
                rp_reg[hit_idx_reg]   <= '0;
                wp_reg[hit_idx_reg]   <= '0;
            end
            if (push_ok)
            begin
                wp_reg[hit_idx_reg] <= ring_next(wp_reg[hit_idx_reg]);
            end
            if (pop_ok)
            begin
                rp_reg[hit_idx_reg] <= ring_next(rp_reg[hit_idx_reg]);
            end
        end
    end

    // descriptor RAM access
    assign ram_we     = cmd.exec && push_ok;
    assign ram_waddr  = ent_addr(hit_idx_reg, wp_reg[hit_idx_reg]);
    assign exec_raddr = ent_addr(hit_idx_reg, rp_reg[hit_idx_reg]);
    assign head_raddr = ent_addr(slot_reg, rp_reg[slot_reg]);
    assign ram_raddr  = cmd.exec ? exec_raddr : head_raddr;
    assign rd_desc    = kmcf_pkg::desc_t'(ram_rdata);

    kmcf_ram #(
        .WIDTH (kmcf_pkg::DESC_W),
        .DEPTH (CHANNELS * DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_desc_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // result registers
    assign fin_cnt = ring_count(rp_reg[slot_reg], wp_reg[slot_reg]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done <= 1'b0;
        end
        else
        begin
            done <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status      <= status_reg;
            out_header  <= desc_reg.header;
            out_source  <= desc_reg.source;
            out_dest    <= desc_reg.dest;
            out_type    <= desc_reg.mtype;
            out_length  <= desc_reg.length;
            out_handle  <= desc_reg.handle;
            now_full    <= !slot_ok_reg || (fin_cnt >= CW'(DEPTH - 1));
            now_empty   <= !slot_ok_reg || (fin_cnt == '0);
            head_length <= (slot_ok_reg && fin_cnt != '0) ? rd_desc.length : '0;
        end
    end

endmodule

// ===== sv/keyed_multi_channel_message_fifo_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_multi_channel_message_fifo_core: keyed multi-channel message FIFO
// Table of CHANNELS keyed rings of message descriptors, DEPTH-1 deep each.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low. Each word passes
// through key lookup, execute, head read and finish, and the result then
// shows on the result ports for one cycle with done high, in the same cycle
// that busy drops. The descriptor RAM has one read port with registered data,
// so a pop reads the popped entry and then the new head entry in turn. No new
// word is taken before the last one is through. The receiver cannot stall:
// done lasts one cycle and must be taken. Descriptor fields are zero for any
// result but a successful pop.
module keyed_multi_channel_message_fifo_core #(
    parameter int CHANNELS = 8,
    parameter int DEPTH    = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [30:0] channel_key,
    input  logic [31:0] header_word,
    input  logic [15:0] source_client,
    input  logic [15:0] dest_client,
    input  logic [15:0] message_type,
    input  logic [23:0] message_length,
    input  logic [31:0] payload_handle,
    output logic        done,
    output logic [2:0]  status,
    output logic [31:0] out_header,
    output logic [15:0] out_source,
    output logic [15:0] out_dest,
    output logic [15:0] out_type,
    output logic [23:0] out_length,
    output logic [31:0] out_handle,
    output logic        now_full,
    output logic        now_empty,
    output logic [23:0] head_length
);

    kmcf_pkg::cmd_t cmd;

    kmcf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    kmcf_dp #(
        .CHANNELS (CHANNELS),
        .DEPTH    (DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .op             (op),
        .channel_key    (channel_key),
        .header_word    (header_word),
        .source_client  (source_client),
        .dest_client    (dest_client),
        .message_type   (message_type),
        .message_length (message_length),
        .payload_handle (payload_handle),
        .done           (done),
        .status         (status),
        .out_header     (out_header),
        .out_source     (out_source),
        .out_dest       (out_dest),
        .out_type       (out_type),
        .out_length     (out_length),
        .out_handle     (out_handle),
        .now_full       (now_full),
        .now_empty      (now_empty),
        .head_length    (head_length)
    );

    // an accepted word always produces its result
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##5 done)
        else $error("result missing after accepted word");

    // a result never appears while a word is still in progress
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // an empty channel reports no head length
    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        (done && now_empty) |-> (head_length == '0))
        else $error("head length on empty channel");

    // header and handle fields are zero on any failed operation
    a_desc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != kmcf_pkg::ST_OK) |-> (out_handle == '0 && out_header == '0))
        else $error("descriptor on failed operation");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the keyed multi-channel message FIFO
// Drives open/close/push/pop command words with random idle gaps, predicts
// each result with a behavioral copy of the channel table and compares every
// done word as one bundle against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

    localparam int CHANNELS  = 8;
    localparam int DEPTH     = 16;
    localparam int MAX_CYCLE = 400000;

    // result fields as one bundle
    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] header;
        logic [15:0] source;
        logic [15:0] dest;
        logic [15:0] mtype;
        logic [23:0] length;
        logic [31:0] handle;
        logic        full;
        logic        empty;
        logic [23:0] head_len;
    } result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  op = kmcf_pkg::OP_OPEN;
    logic [30:0] channel_key = '0;
    logic [31:0] header_word = '0;
    logic [15:0] source_client = '0;
    logic [15:0] dest_client = '0;
    logic [15:0] message_type = '0;
    logic [23:0] message_length = '0;
    logic [31:0] payload_handle = '0;
    logic        done;
    logic [2:0]  status;
    logic [31:0] out_header;
    logic [15:0] out_source;
    logic [15:0] out_dest;
    logic [15:0] out_type;
    logic [23:0] out_length;
    logic [31:0] out_handle;
    logic        now_full;
    logic        now_empty;
    logic [23:0] head_length;

    // predictor state: channel table and descriptor rings
    logic            chan_open [CHANNELS];
    logic [30:0]     chan_key [CHANNELS];
    int              rd_ptr [CHANNELS];
    int              wr_ptr [CHANNELS];
    kmcf_pkg::desc_t ring [CHANNELS][DEPTH];

    result_t     pending_results[$];
    int          mismatches = 0;
    int          cycle = 0;
    bit          idle_on = 1'b1;
    logic [30:0] key_pool [6];

    keyed_multi_channel_message_fifo_core #(
        .CHANNELS(CHANNELS),
        .DEPTH(DEPTH)
    ) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(op),
        .channel_key(channel_key), .header_word(header_word),
        .source_client(source_client), .dest_client(dest_client),
        .message_type(message_type), .message_length(message_length),
        .payload_handle(payload_handle), .done(done), .status(status),
        .out_header(out_header), .out_source(out_source), .out_dest(out_dest),
        .out_type(out_type), .out_length(out_length), .out_handle(out_handle),
        .now_full(now_full), .now_empty(now_empty), .head_length(head_length)
    );

    always #2 clk = ~clk;

    function automatic int ring_fill(int s);
        return (wr_ptr[s] - rd_ptr[s] + DEPTH) % DEPTH;
    endfunction

    // compute the result of one command word and update the table
    function automatic result_t channel_table_step(logic [1:0] cmd, logic [30:0] key,
                                                   kmcf_pkg::desc_t d);
        result_t r;
        int      s;
        int      k;
        bit      any;
        r = '0;
        r.status = kmcf_pkg::ST_OK;
        s = -1;
        any = 1'b0;
        for (k = 0; k < CHANNELS; k++)
        begin
            if (chan_open[k]) any = 1'b1;
            if (s < 0 && chan_open[k] && chan_key[k] == key) s = k;
        end
        if (cmd == kmcf_pkg::OP_OPEN)
        begin
            if (s >= 0) r.status = kmcf_pkg::ST_DUPLICATE;
            else
            begin
                for (k = 0; k < CHANNELS; k++)
                    if (!chan_open[k]) break;
                if (k >= CHANNELS) r.status = kmcf_pkg::ST_TABLE_FULL;
                else
                begin
                    chan_open[k] = 1'b1;
                    chan_key[k] = key;
                    rd_ptr[k] = 0;
                    wr_ptr[k] = 0;
                    s = k;
                end
            end
        end
        else if (!any) r.status = kmcf_pkg::ST_NONE_OPEN;
        else if (s < 0) r.status = kmcf_pkg::ST_NOT_FOUND;
        else if (cmd == kmcf_pkg::OP_CLOSE)
        begin
            chan_open[s] = 1'b0;
            chan_key[s] = '0;
            rd_ptr[s] = 0;
            wr_ptr[s] = 0;
            s = -1;
        end
        else if (cmd == kmcf_pkg::OP_PUSH)
        begin
            if (ring_fill(s) >= DEPTH - 1) r.status = kmcf_pkg::ST_FULL_EMPTY;
            else
            begin
                ring[s][wr_ptr[s]] = d;
                wr_ptr[s] = (wr_ptr[s] + 1) % DEPTH;
            end
        end
        else
        begin
            if (ring_fill(s) == 0) r.status = kmcf_pkg::ST_FULL_EMPTY;
            else
            begin
                r.header = ring[s][rd_ptr[s]].header;
                r.source = ring[s][rd_ptr[s]].source;
                r.dest   = ring[s][rd_ptr[s]].dest;
                r.mtype  = ring[s][rd_ptr[s]].mtype;
                r.length = ring[s][rd_ptr[s]].length;
                r.handle = ring[s][rd_ptr[s]].handle;
                rd_ptr[s] = (rd_ptr[s] + 1) % DEPTH;
            end
        end
        if (s < 0)
        begin
            r.full = 1'b1;
            r.empty = 1'b1;
        end
        else
        begin
            r.full = ring_fill(s) >= DEPTH - 1;
            r.empty = ring_fill(s) == 0;
            r.head_len = r.empty ? 24'd0 : ring[s][rd_ptr[s]].length;
        end
        return r;
    endfunction

    // send one command word, with an optional idle burst first;
    // start stays high after acceptance until the next word or idle burst
    task automatic send_word(logic [1:0] cmd, logic [30:0] key, kmcf_pkg::desc_t d);
        int gap;
        if (idle_on && $urandom_range(0, 2) == 0)
        begin
            gap = $urandom_range(1, 10);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        op <= cmd;
        channel_key <= key;
        header_word <= d.header;
        source_client <= d.source;
        dest_client <= d.dest;
        message_type <= d.mtype;
        message_length <= d.length;
        payload_handle <= d.handle;
        @(posedge clk);
        while (busy) @(posedge clk);
        pending_results = {pending_results, channel_table_step(cmd, key, d)};
    endtask

    function automatic kmcf_pkg::desc_t random_desc();
        kmcf_pkg::desc_t d;
        d.header = $urandom;
        d.source = 16'($urandom);
        d.dest   = 16'($urandom);
        d.mtype  = 16'($urandom);
        d.length = 24'($urandom);
        d.handle = $urandom;
        return d;
    endfunction

    // check each done word against the oldest prediction
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        cycle <= cycle + 1;
        if (rst_n && done)
        begin
            got = {status, out_header, out_source, out_dest, out_type, out_length,
                   out_handle, now_full, now_empty, head_length};
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", got);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h got %h", want, got);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (cycle > MAX_CYCLE)
        begin
            $display("tb failed");
            $finish;
        end
    end

    // extremes, duplicates, empty/none-open paths, fill to full and close
    task automatic test_directed();
        kmcf_pkg::desc_t d;
        int              i;
        d = random_desc();
        send_word(kmcf_pkg::OP_POP, 31'd5, d);
        send_word(kmcf_pkg::OP_CLOSE, 31'd5, d);
        send_word(kmcf_pkg::OP_PUSH, 31'd5, d);
        send_word(kmcf_pkg::OP_OPEN, 31'h7fffffff, d);
        send_word(kmcf_pkg::OP_OPEN, 31'h7fffffff, d);
        send_word(kmcf_pkg::OP_POP, 31'h7fffffff, d);
        send_word(kmcf_pkg::OP_PUSH, 31'd0, d);
        send_word(kmcf_pkg::OP_PUSH, 31'h7fffffff, '1);
        send_word(kmcf_pkg::OP_PUSH, 31'h7fffffff, '0);
        send_word(kmcf_pkg::OP_POP, 31'h7fffffff, d);
        send_word(kmcf_pkg::OP_POP, 31'h7fffffff, d);
        for (i = 0; i < DEPTH; i++)
            send_word(kmcf_pkg::OP_PUSH, 31'h7fffffff, random_desc());
        send_word(kmcf_pkg::OP_CLOSE, 31'h7fffffff, d);
    endtask

    // fill the table, hit table full, then close everything
    task automatic test_table_full();
        int i;
        for (i = 0; i <= CHANNELS; i++)
            send_word(kmcf_pkg::OP_OPEN, 31'(i), random_desc());
        for (i = 0; i < CHANNELS; i++)
            send_word(kmcf_pkg::OP_CLOSE, 31'(i), random_desc());
    endtask

    // random traffic over a small key pool, mostly push/pop
    task automatic test_random(int count);
        int          i;
        int          sel;
        logic [1:0]  cmd;
        logic [30:0] key;
        for (i = 0; i < 6; i++) key_pool[i] = 31'($urandom);
        key_pool[0] = 31'd0;
        key_pool[1] = 31'h7fffffff;
        for (i = 0; i < count; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 10) cmd = kmcf_pkg::OP_OPEN;
            else if (sel < 16) cmd = kmcf_pkg::OP_CLOSE;
            else if (sel < 60) cmd = kmcf_pkg::OP_PUSH;
            else cmd = kmcf_pkg::OP_POP;
            key = ($urandom_range(0, 19) == 0) ? 31'($urandom)
                                                : key_pool[$urandom_range(0, 5)];
            if (i > count * 3 / 4) idle_on = 1'b0;
            send_word(cmd, key, random_desc());
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_table_full();
        test_random(1000);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule

// ===== sim.f =====
sv/kmcf_pkg.sv
sv/kmcf_ram.sv
sv/kmcf_ctrl.sv
sv/kmcf_dp.sv
sv/keyed_multi_channel_message_fifo_core.sv
tb/tb.sv
